// ===== hdl/ewps_pkg.sv =====
`default_nettype none
package ewps_pkg;

  localparam int WHEELS = 4;
  localparam int DW = 16;
  // quotient bits: a factor below 1.0 fits in 15 bits
  localparam int QB = 15;
  localparam int TW = $clog2(WHEELS * 32768 + 1);
  localparam int NW = 32 + $clog2(WHEELS);
  localparam int SATW = (NW > TW + QB) ? NW : TW + QB;
  // front stage, numerator stage, divider setup, QB steps, output register
  localparam int NS = QB + 4;
  localparam int IN_W = DW * (1 + 2 * WHEELS);
  localparam int OUT_W = DW * WHEELS;

  localparam logic [DW-1:0] ONE_Q15 = 16'h8000;
  localparam logic [DW-1:0] TOL_RESET = 16'd33;

  typedef struct packed {
    logic pass;
    logic zero;
    logic [DW-1:0] zfac;
    logic [TW-1:0] total;
  } ewps_side_t;

  typedef logic [DW-1:0] ewps_word_t;

endpackage
`default_nettype wire

// ===== hdl/ewps_front.sv =====
`default_nettype none
module ewps_front
  import ewps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [1:0] en,
  input  wire ewps_word_t tol,
  input  wire ewps_word_t ratio,
  input  wire ewps_word_t err [WHEELS],
  input  wire ewps_word_t demand [WHEELS],
  output ewps_word_t      ratio0,
  output ewps_word_t      abs0 [WHEELS],
  output ewps_word_t      dem0 [WHEELS],
  output ewps_side_t      side1
);

  ewps_word_t ratio_r;
  ewps_word_t abs_r [WHEELS];
  ewps_word_t dem_r [WHEELS];
  logic       pass_r;
  ewps_side_t side_r;

  ewps_word_t offset;
  logic [TW-1:0] total;

  assign offset = (ratio >= ONE_Q15) ? ratio - ONE_Q15 : ONE_Q15 - ratio;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ratio_r <= ratio;
      pass_r  <= (offset <= tol);
      for (int i = 0; i < WHEELS; i++) begin
        // -32768 maps to 32768, which still fits unsigned
        abs_r[i] <= err[i][DW-1] ? DW'(-err[i]) : err[i];
        dem_r[i] <= demand[i];
      end
    end
  end

  // merge point: the lanes' errors combine into one total
  always_comb begin
    total = '0;
    for (int i = 0; i < WHEELS; i++) begin
      total = total + TW'(abs_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r.pass  <= pass_r;
      side_r.zero  <= (total == '0);
      side_r.zfac  <= (ratio_r > ONE_Q15) ? ONE_Q15 : ratio_r;
      side_r.total <= total;
    end
  end

  assign ratio0 = ratio_r;
  assign abs0   = abs_r;
  assign dem0   = dem_r;
  assign side1  = side_r;

endmodule
`default_nettype wire

// ===== hdl/ewps_lane.sv =====
`default_nettype none
module ewps_lane
  import ewps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [NS-1:0]           en,
  input  wire ewps_word_t              ratio0,
  input  wire ewps_word_t              abs0,
  input  wire ewps_word_t              dem0,
  input  wire ewps_side_t [NS-2:1]     side,
  output ewps_word_t                   drive
);

  logic [NW-1:0] num1_r;
  ewps_word_t    dem_r [1:NS-2];
  logic          sat_r [2:NS-2];
  logic [TW-1:0] rem_r [2:NS-2];
  logic [QB-1:0] low_r [2:NS-2];
  logic [QB-1:0] q_r   [2:NS-2];
  ewps_word_t    drive_r;

  // numerator WHEELS * ratio * |err|
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1_r   <= NW'(WHEELS) * NW'(32'(ratio0) * 32'(abs0));
      dem_r[1] <= dem0;
    end
  end

  // saturation test and the divider's starting remainder
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sat_r[2] <= SATW'(num1_r) >= SATW'({side[1].total, QB'(0)});
      rem_r[2] <= num1_r[TW+QB-1:QB];
      low_r[2] <= num1_r[QB-1:0];
      q_r[2]   <= '0;
      dem_r[2] <= dem_r[1];
    end
  end

  // one restoring quotient bit per stage, msb first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = 3 + j;
    logic [TW:0] trial;
    logic        fit;
    assign trial = {rem_r[K-1], low_r[K-1][QB-1-j]};
    assign fit   = trial >= {1'b0, side[K-1].total};
    always_ff @(posedge clk) begin
      if (en[K]) begin
        rem_r[K] <= fit ? TW'(trial - {1'b0, side[K-1].total}) : trial[TW-1:0];
        q_r[K]   <= {q_r[K-1][QB-2:0], fit};
        low_r[K] <= low_r[K-1];
        sat_r[K] <= sat_r[K-1];
        dem_r[K] <= dem_r[K-1];
      end
    end
  end

  ewps_word_t    factor;
  ewps_word_t    dmag;
  logic [31:0]   prod;
  logic [DW:0]   mag;
  logic [DW:0]   sval;
  logic          neg;

  always_comb begin
    if (side[NS-2].zero) begin
      factor = side[NS-2].zfac;
    end else if (sat_r[NS-2]) begin
      factor = ONE_Q15;
    end else begin
      factor = {1'b0, q_r[NS-2]};
    end
    neg  = dem_r[NS-2][DW-1];
    dmag = neg ? DW'(-dem_r[NS-2]) : dem_r[NS-2];
    prod = 32'(dmag) * 32'(factor);
    mag  = prod[31:QB];
    // truncation toward zero: scale the magnitude, then restore the sign
    sval = neg ? (DW+1)'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      drive_r <= side[NS-2].pass ? dem_r[NS-2] : sval[DW-1:0];
    end
  end

  assign drive = drive_r;

endmodule
`default_nettype wire

// ===== hdl/error_weighted_power_split.sv =====
// error weighted power split
//
// input stream (in_*): one transfer carries the power ratio, the wheel speed
// errors and the motor demands; output stream (out_*): one transfer carries
// the drives, with out_tuser high when scaling was applied. cfg_wen writes
// the pass tolerance (q1.15) from cfg_wdata; write it only while idle.
//
// each wheel has its own lane: numerator multiply, a 15 step restoring
// divider (one quotient bit per stage) and the final demand multiply. the
// lanes share the error total and the pass decision from the front stage.
// the divider stages set the pipeline depth. throughput is one item per
// cycle while out_tready is high or a pipeline stage is empty.
//
// reset clears every stage valid bit and sets the tolerance to 33.
// when out_tready is low the result holds in the output register and
// in_tready stays high as long as any pipeline stage is empty, so bubbles
// collapse; in_tready falls only once all 19 stages hold items.
`default_nettype none
module error_weighted_power_split
  import ewps_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // power_ratio, speed_err_0..3, demand_0..3
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // drive_0..3
  output logic [OUT_W-1:0]     out_tdata,
  // scaled
  output logic                 out_tuser,
  input  wire logic            cfg_wen,
  input  wire logic [DW-1:0]   cfg_wdata
);

  ewps_word_t            tol_r;
  logic [NS-1:0]         valid_r;
  logic [NS-1:0]         en;
  logic                  scaled_r;
  ewps_side_t            side_r [2:NS-2];
  ewps_side_t [NS-2:1]   side_line;

  ewps_word_t ratio;
  ewps_word_t err [WHEELS];
  ewps_word_t demand [WHEELS];
  ewps_word_t ratio0;
  ewps_word_t abs0 [WHEELS];
  ewps_word_t dem0 [WHEELS];
  ewps_word_t drive [WHEELS];
  ewps_side_t side1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wen) begin
      tol_r <= cfg_wdata;
    end
  end

  // a stage moves when it is empty or everything below it can move
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~(&valid_r[NS-1:k]) | out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NS-1];

  assign ratio = in_tdata[DW-1:0];
  for (genvar i = 0; i < WHEELS; i++) begin : g_unpack
    assign err[i]    = in_tdata[DW*(1+i) +: DW];
    assign demand[i] = in_tdata[DW*(1+WHEELS+i) +: DW];
  end

  ewps_front u_front (
    .clk    (clk),
    .en     (en[1:0]),
    .tol    (tol_r),
    .ratio  (ratio),
    .err    (err),
    .demand (demand),
    .ratio0 (ratio0),
    .abs0   (abs0),
    .dem0   (dem0),
    .side1  (side1)
  );

  // shared per-item control travels beside the lanes
  assign side_line[1] = side1;
  for (genvar k = 2; k <= NS-2; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_line[k-1];
      end
    end
    assign side_line[k] = side_r[k];
  end

  for (genvar i = 0; i < WHEELS; i++) begin : g_lane
    ewps_lane u_lane (
      .clk    (clk),
      .en     (en),
      .ratio0 (ratio0),
      .abs0   (abs0[i]),
      .dem0   (dem0[i]),
      .side   (side_line),
      .drive  (drive[i])
    );
    assign out_tdata[DW*i +: DW] = drive[i];
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      scaled_r <= ~side_line[NS-2].pass;
    end
  end

  assign out_tuser = scaled_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> valid_r == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[0])
    else $error("accepted transfer did not enter the first stage");

  a_held_items_stay: assert property (@(posedge clk) disable iff (!rst_n)
    |(valid_r & ~en) |=> (valid_r & $past(valid_r & ~en)) == $past(valid_r & ~en))
    else $error("stalled item dropped from the pipeline");

endmodule
`default_nettype wire

// ===== sim/error_weighted_power_split_tb.sv =====
`timescale 1ns / 100ps
module error_weighted_power_split_tb
  import ewps_pkg::*;
();

  localparam int unsigned UNITY = 32768;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = NS + 12;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int HOLD_CYCLES = 250;

  // scaled flag on top, drive_3..drive_0 below
  typedef logic [OUT_W:0] result_t;

  typedef struct {
    logic [IN_W-1:0] data;
    bit              known;
    result_t         want;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_wen;
  logic [DW-1:0]    cfg_wdata;

  result_t       pending_drives[$];
  row_t          directed_rows[$];
  logic [DW-1:0] tolerance;
  int            errors;
  int            results_seen;
  int            cycles;
  int            burst_left;

  error_weighted_power_split u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_item(input logic [DW-1:0] ratio,
      input logic [DW-1:0] e0, e1, e2, e3, d0, d1, d2, d3);
    return {d3, d2, d1, d0, e3, e2, e1, e0, ratio};
  endfunction

  function automatic result_t pack_result(input logic scaled,
      input logic [DW-1:0] d0, d1, d2, d3);
    return {scaled, d3, d2, d1, d0};
  endfunction

  // share the power limit among the wheels by their part of the total error; inside the pass window the demands pass
  function automatic result_t split_drives(input logic [IN_W-1:0] item,
      input logic [DW-1:0] tol);
    int unsigned       ratio;
    int unsigned       offset;
    longint unsigned   err_mag[WHEELS];
    longint unsigned   total;
    longint unsigned   factor;
    longint unsigned   mag;
    longint unsigned   word;
    int                err;
    int                dem;
    result_t           res;
    ratio = item[DW-1:0];
    offset = (ratio >= UNITY) ? ratio - UNITY : UNITY - ratio;
    if (offset <= tol) begin
      return {1'b0, item[IN_W-1 -: OUT_W]};
    end
    total = 0;
    for (int i = 0; i < WHEELS; i++) begin
      err = $signed(item[DW*(1+i) +: DW]);
      err_mag[i] = (err < 0) ? -err : err;
      total += err_mag[i];
    end
    for (int i = 0; i < WHEELS; i++) begin
      if (total == 0) begin
        factor = ratio;
      end else begin
        factor = longint'(WHEELS) * longint'(ratio) * err_mag[i] / total;
      end
      if (factor > UNITY) begin
        factor = UNITY;
      end
      dem = $signed(item[DW*(1+WHEELS+i) +: DW]);
      mag = longint'((dem < 0) ? -dem : dem) * factor / UNITY;
      word = (dem < 0) ? 64'd0 - mag : mag;
      res[DW*i +: DW] = word[DW-1:0];
    end
    res[OUT_W] = 1'b1;
    return res;
  endfunction

  function automatic logic [IN_W-1:0] rand_item(input logic [DW-1:0] tol);
    logic [DW-1:0] ratio;
    logic [DW-1:0] e[WHEELS];
    logic [DW-1:0] d[WHEELS];
    int            near;
    int            sel;
    bit            quiet;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ratio = 16'($urandom_range(0, UNITY));
      4, 5: begin
        // straddle the pass window
        near = int'(UNITY) + int'($urandom_range(0, 2 * int'(tol) + 4)) - int'(tol) - 2;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        ratio = 16'(near);
      end
      6: ratio = ($urandom_range(0, 1) != 0) ? 16'd0 : ONE_Q15;
      7: ratio = 16'($urandom_range(UNITY + 1, 65535));
      8: ratio = 16'($urandom);
      default: ratio = 16'($urandom_range(0, 64));
    endcase
    quiet = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < WHEELS; i++) begin
      sel = $urandom_range(0, 9);
      if (quiet || sel < 2) e[i] = '0;
      else if (sel == 2) e[i] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      else if (sel < 5) e[i] = 16'($urandom_range(0, 200)) - 16'd100;
      else e[i] = 16'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        case ($urandom_range(0, 2))
          0: d[i] = 16'h4000;
          1: d[i] = 16'hC000;
          default: d[i] = 16'h8000;
        endcase
      end else if (sel == 1) begin
        d[i] = 16'($urandom);
      end else begin
        d[i] = 16'($urandom_range(0, 32768)) - 16'd16384;
      end
    end
    return pack_item(ratio, e[0], e[1], e[2], e[3], d[0], d[1], d[2], d[3]);
  endfunction

  task automatic add_row(input logic [IN_W-1:0] data);
    directed_rows.push_back('{data: data, known: 1'b0, want: '0});
  endtask

  task automatic add_known(input logic [IN_W-1:0] data, input result_t want);
    directed_rows.push_back('{data: data, known: 1'b1, want: want});
  endtask

  task automatic send_item(input logic [IN_W-1:0] data, input bit known,
      input result_t want);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1: gap = 0;
        2, 3: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    pending_drives.push_back(known ? want : split_drives(data, tolerance));
  endtask

  // stop offering, wait for every pending result, then let the pipe go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_tolerance(input logic [DW-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tolerance = value;
  endtask

  initial begin
    logic [DW-1:0] phase_tol[5];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    tolerance = TOL_RESET;

    // directed rows run with the tolerance left at its reset value
    add_known(pack_item(16'h8000, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
                        16'sd16384, -16'sd16384, 16'sd1000, -16'sd1),
              pack_result(1'b0, 16'sd16384, -16'sd16384, 16'sd1000, -16'sd1));
    add_known(pack_item(16'd32801, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
                        16'sd16384, -16'sd16384, 16'sd1000, -16'sd1),
              pack_result(1'b0, 16'sd16384, -16'sd16384, 16'sd1000, -16'sd1));
    add_known(pack_item(16'd32735, 16'sd7, 16'sd7, 16'sd7, 16'sd7,
                        16'h8000, 16'sd16384, 16'sd0, 16'sd5),
              pack_result(1'b0, 16'h8000, 16'sd16384, 16'sd0, 16'sd5));
    add_row(pack_item(16'd32734, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
                      16'sd16384, -16'sd16384, 16'sd1000, -16'sd1));
    // zero ratio kills every drive
    add_known(pack_item(16'd0, 16'h8000, 16'h7FFF, 16'sd1, -16'sd1,
                        16'sd16384, -16'sd16384, 16'h8000, 16'sd12345),
              pack_result(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // no error at all: every factor is the ratio itself
    add_known(pack_item(16'd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        16'sd16384, -16'sd16384, 16'sd1001, -16'sd1001),
              pack_result(1'b1, 16'sd8192, -16'sd8192, 16'sd500, -16'sd500));
    // ratio above one saturates, full negative demand survives
    add_known(pack_item(16'hFFFF, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000,
                        16'h8000, 16'sd16384, -16'sd16384, 16'sd7),
              pack_result(1'b1, 16'h8000, 16'sd16384, -16'sd16384, 16'sd7));
    add_known(pack_item(16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        16'sd16383, -16'sd16383, 16'h8000, -16'sd7),
              pack_result(1'b1, 16'sd16383, -16'sd16383, 16'h8000, -16'sd7));
    add_known(pack_item(16'd10000, 16'sd0, 16'sd0, 16'sd0, -16'sd5,
                        16'sd1000, 16'sd1000, 16'sd1000, -16'sd1000),
              pack_result(1'b1, 16'sd0, 16'sd0, 16'sd0, -16'sd1000));
    add_known(pack_item(16'd8192, 16'h8000, 16'sd0, 16'sd0, 16'sd0,
                        -16'sd12345, 16'sd500, 16'sd500, 16'sd500),
              pack_result(1'b1, -16'sd12345, 16'sd0, 16'sd0, 16'sd0));
    add_known(pack_item(16'd32767, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h7FFF, 16'sd0, -16'sd1),
              pack_result(1'b0, 16'h8000, 16'h7FFF, 16'sd0, -16'sd1));
    add_known(pack_item(16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        16'sd16384, -16'sd16384, 16'h8000, 16'sd1),
              pack_result(1'b0, 16'sd16384, -16'sd16384, 16'h8000, 16'sd1));
    add_row(pack_item(16'd20000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                      16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384));
    add_row(pack_item(16'd1, 16'sd1, 16'sd2, 16'sd3, 16'sd4,
                      16'sd16384, -16'sd16384, 16'sd9999, -16'sd9999));
    add_row(pack_item(16'd40000, 16'sd5000, -16'sd100, 16'sd0, 16'sd30000,
                      16'sd12000, -16'sd12000, 16'sd16384, -16'sd16384));
    add_row(pack_item(16'd24576, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
                      16'sd16384, -16'sd16384, 16'sd3, -16'sd3));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].data, directed_rows[i].known, directed_rows[i].want);
    end
    drain();

    phase_tol[0] = '0;
    phase_tol[1] = ONE_Q15;
    phase_tol[2] = 16'($urandom_range(1, 4000));
    phase_tol[3] = TOL_RESET;
    phase_tol[4] = 16'($urandom_range(4001, 32767));
    foreach (phase_tol[p]) begin
      write_tolerance(phase_tol[p]);
      repeat (RANDOM_PER_PHASE) send_item(rand_item(tolerance), 1'b0, '0);
      drain();
    end

    if (errors == 0 && pending_drives.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result checker and receiver back-pressure
  initial begin
    result_t     want;
    logic [15:0] stall_pat;
    int          stall_pos;
    int          hold_left;
    int          hold_mark;
    stall_pat = '1;
    stall_pos = 0;
    hold_left = 0;
    hold_mark = 60;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (pending_drives.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer on out_* with nothing pending");
        end else begin
          want = pending_drives.pop_front();
          for (int i = 0; i < WHEELS; i++) begin
            if (out_tdata[DW*i +: DW] !== want[DW*i +: DW]) begin
              errors++;
              if (errors <= 10) begin
                $display("drive_%0d mismatch: expected %0d, got %0d", i,
                         $signed(want[DW*i +: DW]), $signed(out_tdata[DW*i +: DW]));
              end
            end
          end
          if (out_tuser !== want[OUT_W]) begin
            errors++;
            if (errors <= 10) begin
              $display("scaled mismatch: expected %0b, got %0b", want[OUT_W], out_tuser);
            end
          end
        end
      end
      // long hold-off now and then so the pipe fills and stalls the input
      if (hold_left == 0 && results_seen >= hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark += 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (stall_pos == 0) begin
          stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
        end
        out_tready <= stall_pat[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
